// ===== rtl/core/lecd_pkg.sv =====
// ----------------------------------------------------------------------------
// lecd_pkg: shared types and constants for the column density block
// Register codes, reset values, queue sizing and the request/response
// structs of the shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

package lecd_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_REF_DENSITY     = CFG_INDEX_W'(0),
		CFG_REF_TEMPERATURE = CFG_INDEX_W'(1),
		CFG_REF_SALINITY    = CFG_INDEX_W'(2),
		CFG_THERMAL_COEF    = CFG_INDEX_W'(3),
		CFG_HALINE_COEF     = CFG_INDEX_W'(4),
		CFG_MEAN_DENSITY    = CFG_INDEX_W'(5)
	} cfg_idx_t;

	localparam logic [30:0]        RST_REF_DENSITY     = 31'd67305472;
	localparam logic signed [31:0] RST_REF_TEMPERATURE = 32'sd655360;
	localparam logic signed [31:0] RST_REF_SALINITY    = 32'sd2293760;
	localparam logic signed [31:0] RST_THERMAL_COEF    = 32'sd182536;
	localparam logic signed [31:0] RST_HALINE_COEF     = 32'sd822084;
	localparam logic [30:0]        RST_MEAN_DENSITY    = 31'd67305472;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int MUL_A_W    = 64;
	localparam int MUL_B_W    = 33;
	localparam int MUL_HALF_W = 32;
	localparam int MUL_PP_W   = MUL_HALF_W + MUL_B_W;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

	localparam int DIV_NUM_W       = 64;
	localparam int DIV_MAG_W       = 63;
	localparam int DIV_DEN_W       = 97;
	localparam int DIV_SHIFT_RATIO = 64;
	localparam int DIV_SHIFT_PERT  = 81;
	localparam int DIV_POS_W       = 8;
	localparam int DIV_TOP_RATIO   = DIV_NUM_W + DIV_SHIFT_RATIO - 1;
	localparam int DIV_TOP_PERT    = DIV_NUM_W + DIV_SHIFT_PERT - 1;

	localparam logic [DIV_MAG_W-1:0] MAG_MAX = '1;

	typedef struct packed {
		logic [30:0] r0;
		logic        tc_neg;
		logic [31:0] tc_mag;
		logic        sc_neg;
		logic [31:0] sc_mag;
		logic [30:0] rho0;
	} cfg_t;

	typedef struct packed {
		logic        dt_neg;
		logic [31:0] dt_mag;
		logic        ds_neg;
		logic [31:0] ds_mag;
		logic [30:0] hz;
		logic        d_neg;
		logic [32:0] d_mag;
		logic        last;
	} item_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic [MUL_P_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic                 start;
		logic                 pert;
		logic [DIV_MAG_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_MAG_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/lecd_if.sv =====
// ----------------------------------------------------------------------------
// lecd_if: level and result channels
// Valid/ready channels carrying one water-column level in and one result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lecd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature;
	logic signed [31:0] salinity;
	logic [30:0]        layer_thickness;
	logic signed [31:0] surface_height;
	logic signed [31:0] bottom_depth;
	logic               last_level;

	modport source (output valid, temperature, salinity, layer_thickness,
		surface_height, bottom_depth, last_level, input ready);
	modport sink (input valid, temperature, salinity, layer_thickness,
		surface_height, bottom_depth, last_level, output ready);
endinterface

interface lecd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] density_anomaly;
	logic               column_done;
	logic signed [63:0] mean_density_ratio;
	logic signed [63:0] density_perturbation;
	logic               depth_error;

	modport source (output valid, density_anomaly, column_done, mean_density_ratio,
		density_perturbation, depth_error, input ready);
	modport sink (input valid, density_anomaly, column_done, mean_density_ratio,
		density_perturbation, depth_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lecd_front.sv =====
// ----------------------------------------------------------------------------
// lecd_front: level intake and configuration registers
// Holds the register file, forms temperature and salinity offsets and the
// total depth as sign and magnitude, and pushes each level into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lecd_front (
	input  logic                             clk,
	input  logic                             arst_n,
	lecd_in_if.sink                          levels,
	input  logic                             cfg_wr_en,
	input  logic [lecd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lecd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output lecd_pkg::cfg_t                   cfg,
	output lecd_pkg::item_t                  item,
	output logic                             push,
	input  logic                             full
);
	import lecd_pkg::*;

	logic [30:0]        ref_density_q;
	logic signed [31:0] ref_temperature_q;
	logic signed [31:0] ref_salinity_q;
	logic signed [31:0] thermal_coef_q;
	logic signed [31:0] haline_coef_q;
	logic [30:0]        mean_density_q;
	logic [32:0]        dt;
	logic [32:0]        ds;
	logic [32:0]        d;
	logic [32:0]        dt_abs;
	logic [32:0]        ds_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_density_q     <= RST_REF_DENSITY;
			ref_temperature_q <= RST_REF_TEMPERATURE;
			ref_salinity_q    <= RST_REF_SALINITY;
			thermal_coef_q    <= RST_THERMAL_COEF;
			haline_coef_q     <= RST_HALINE_COEF;
			mean_density_q    <= RST_MEAN_DENSITY;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_REF_DENSITY:     ref_density_q     <= cfg_data[30:0];
				CFG_REF_TEMPERATURE: ref_temperature_q <= cfg_data;
				CFG_REF_SALINITY:    ref_salinity_q    <= cfg_data;
				CFG_THERMAL_COEF:    thermal_coef_q    <= cfg_data;
				CFG_HALINE_COEF:     haline_coef_q     <= cfg_data;
				CFG_MEAN_DENSITY:    mean_density_q    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.r0     = ref_density_q;
		cfg.tc_neg = thermal_coef_q[31];
		cfg.tc_mag = thermal_coef_q[31] ? (~thermal_coef_q + 32'd1) : thermal_coef_q;
		cfg.sc_neg = haline_coef_q[31];
		cfg.sc_mag = haline_coef_q[31] ? (~haline_coef_q + 32'd1) : haline_coef_q;
		cfg.rho0   = mean_density_q;
	end

	// offsets are formed one bit wider so they never wrap
	assign dt = {levels.temperature[31], levels.temperature}
		- {ref_temperature_q[31], ref_temperature_q};
	assign ds = {levels.salinity[31], levels.salinity}
		- {ref_salinity_q[31], ref_salinity_q};
	assign d  = {levels.surface_height[31], levels.surface_height}
		+ {levels.bottom_depth[31], levels.bottom_depth};
	assign dt_abs = dt[32] ? (~dt + 33'd1) : dt;
	assign ds_abs = ds[32] ? (~ds + 33'd1) : ds;

	always_comb begin
		item.dt_neg = dt[32];
		item.dt_mag = dt_abs[31:0];
		item.ds_neg = ds[32];
		item.ds_mag = ds_abs[31:0];
		item.hz     = levels.layer_thickness;
		item.d_neg  = d[32];
		item.d_mag  = d[32] ? (~d + 33'd1) : d;
		item.last   = levels.last_level;
	end

	assign levels.ready = !full;
	assign push         = levels.valid && !full;

endmodule

`default_nettype wire

// ===== rtl/core/lecd_queue.sv =====
// ----------------------------------------------------------------------------
// lecd_queue: level queue between intake and arithmetic
// Small FIFO of classified levels so either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lecd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  lecd_pkg::item_t wr_item,
	input  logic            push,
	output logic            full,
	output lecd_pkg::item_t rd_item,
	output logic            empty,
	input  logic            pop
);
	import lecd_pkg::*;

	item_t                  entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full    = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lecd_mul.sv =====
// ----------------------------------------------------------------------------
// lecd_mul: shared unsigned 64x33 multiplier
// One 32x33 partial product per cycle: the low half is registered on start,
// then the high half is added in; done pulses for one cycle with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lecd_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  lecd_pkg::mul_req_t req,
	output lecd_pkg::mul_rsp_t rsp
);
	import lecd_pkg::*;

	logic [MUL_P_W-1:0]         prod_q;
	logic [MUL_A_W-MUL_HALF_W-1:0] a_hi_q;
	logic [MUL_B_W-1:0]         b_q;
	logic                       hi_q;
	logic                       done_q;
	logic [MUL_PP_W-1:0]        pp_lo;
	logic [MUL_PP_W-1:0]        pp_hi;

	assign pp_lo = MUL_PP_W'(req.a[MUL_HALF_W-1:0]) * MUL_PP_W'(req.b);
	assign pp_hi = MUL_PP_W'(a_hi_q) * MUL_PP_W'(b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			hi_q   <= req.start;
			done_q <= hi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= MUL_P_W'(pp_lo);
			a_hi_q <= req.a[MUL_A_W-1:MUL_HALF_W];
			b_q    <= req.b;
		end else if (hi_q) begin
			prod_q <= prod_q + {pp_hi, MUL_HALF_W'(0)};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule

`default_nettype wire

// ===== rtl/core/lecd_div.sv =====
// ----------------------------------------------------------------------------
// lecd_div: radix-2 rounding divider
// Computes round(num * 2^shift / den), ties away from zero, capped at the
// largest positive 64-bit value. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lecd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lecd_pkg::div_req_t req,
	output lecd_pkg::div_rsp_t rsp
);
	import lecd_pkg::*;

	typedef enum logic [1:0] {DS_IDLE, DS_RUN, DS_ROUND} div_state_t;

	div_state_t           state_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_MAG_W-1:0] quot_q;
	logic [DIV_MAG_W-1:0] res_q;
	logic [DIV_POS_W-1:0] pos_q;
	logic                 ovf_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_sub;
	logic                 ge;
	logic                 round_up;

	assign rem_sh   = {rem_q, num_q[DIV_NUM_W-1]};
	assign ge       = rem_sh >= {1'b0, den_q};
	assign rem_sub  = rem_sh - {1'b0, den_q};
	assign round_up = {rem_q, 1'b0} >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			done_q  <= 1'b0;
			rem_q   <= '0;
			den_q   <= '0;
			num_q   <= '0;
			quot_q  <= '0;
			res_q   <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DS_IDLE: begin
					if (req.start) begin
						rem_q   <= '0;
						den_q   <= req.den;
						num_q   <= {1'b0, req.num};
						quot_q  <= '0;
						ovf_q   <= 1'b0;
						pos_q   <= req.pert ? DIV_POS_W'(DIV_TOP_PERT)
							: DIV_POS_W'(DIV_TOP_RATIO);
						state_q <= DS_RUN;
					end
				end
				DS_RUN: begin
					rem_q  <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
					num_q  <= {num_q[DIV_NUM_W-2:0], 1'b0};
					quot_q <= {quot_q[DIV_MAG_W-2:0], ge};
					// a quotient bit at weight 2^63 or above saturates the result
					if (ge && pos_q >= DIV_POS_W'(DIV_MAG_W)) begin
						ovf_q <= 1'b1;
					end
					if (pos_q == '0) begin
						state_q <= DS_ROUND;
					end else begin
						pos_q <= pos_q - DIV_POS_W'(1);
					end
				end
				DS_ROUND: begin
					if (ovf_q) begin
						res_q <= MAG_MAX;
					end else if (round_up && quot_q != MAG_MAX) begin
						res_q <= quot_q + DIV_MAG_W'(1);
					end else begin
						res_q <= quot_q;
					end
					done_q  <= 1'b1;
					state_q <= DS_IDLE;
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/lecd_back.sv =====
// ----------------------------------------------------------------------------
// lecd_back: density and column-average sequencer
// Pops one level, steps the shared multiplier through the equation of
// state and the running sums, runs the two divisions on a last level with
// nonzero depth product, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lecd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lecd_pkg::cfg_t  cfg,
	input  lecd_pkg::item_t q_item,
	input  logic            q_empty,
	output logic            pop,
	lecd_out_if.source      results
);
	import lecd_pkg::*;

	localparam int TERM_W = 53;
	localparam int SUM_W  = 54;
	localparam logic signed [SUM_W-1:0] ANOMALY_OFFSET = 54'sd65536000;
	localparam logic signed [SUM_W-1:0] RHO_MAX = 54'sd2147483647;
	localparam logic signed [SUM_W-1:0] RHO_MIN = -54'sd2147483648;
	localparam logic signed [64:0] ACC_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] ACC_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ISSUE, ST_MWAIT, ST_RHO, ST_INNER, ST_ACC,
		ST_DISSUE, ST_DWAIT, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_TC, OP_TD, OP_SC, OP_SD, OP_CFF, OP_MOM, OP_D1, OP_D2
	} op_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > ACC_MAX) begin
			return ACC_MAX[63:0];
		end else if (s < ACC_MIN) begin
			return ACC_MIN[63:0];
		end
		return s[63:0];
	endfunction

	state_t              state_q;
	op_t                 op_q;
	item_t               item_q;
	logic [61:0]         p1_q;
	logic                p1_neg_q;
	logic signed [TERM_W-1:0] tt_q;
	logic signed [TERM_W-1:0] ts_q;
	logic signed [31:0]  rho_q;
	logic signed [63:0]  cff_q;
	logic signed [63:0]  inner_q;
	logic signed [63:0]  inc_q;
	logic signed [63:0]  ws_q;
	logic signed [63:0]  ms_q;
	logic [63:0]         den1_q;
	logic [DIV_DEN_W-1:0] den2_q;
	logic                err_q;
	logic signed [63:0]  ratio_q;
	logic signed [63:0]  pert_q;
	logic                div_pert_q;
	logic                out_valid_q;
	logic signed [31:0]  out_rho_q;
	logic                out_done_q;
	logic signed [63:0]  out_ratio_q;
	logic signed [63:0]  out_pert_q;
	logic                out_err_q;

	mul_req_t            mul_req;
	mul_rsp_t            mul_rsp;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic [31:0]         rho_mag;
	logic [63:0]         inner_abs;
	logic [63:0]         ws_abs;
	logic [63:0]         ms_abs;
	logic [MUL_P_W-1:0]  rnd46;
	logic [MUL_P_W-1:0]  rnd16;
	logic [MUL_P_W-1:0]  rnd17;
	logic [TERM_W-1:0]   term_mag;
	logic [TERM_W-1:0]   term_neg;
	logic [63:0]         cff_mag;
	logic [63:0]         inc_mag;
	logic [63:0]         quot_ext;
	logic signed [SUM_W-1:0] rho_sum;
	logic                out_free;

	lecd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	lecd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign rho_mag   = rho_q[31] ? (~rho_q + 32'd1) : rho_q;
	assign inner_abs = inner_q[63] ? (~inner_q + 64'd1) : inner_q;
	assign ws_abs    = ws_q[63] ? (~ws_q + 64'd1) : ws_q;
	assign ms_abs    = ms_q[63] ? (~ms_q + 64'd1) : ms_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_req.start = (state_q == ST_ISSUE);
		unique case (op_q)
			OP_TC: begin
				mul_req.a = MUL_A_W'(cfg.r0);
				mul_req.b = MUL_B_W'(cfg.tc_mag);
			end
			OP_TD: begin
				mul_req.a = MUL_A_W'(p1_q);
				mul_req.b = MUL_B_W'(item_q.dt_mag);
			end
			OP_SC: begin
				mul_req.a = MUL_A_W'(cfg.r0);
				mul_req.b = MUL_B_W'(cfg.sc_mag);
			end
			OP_SD: begin
				mul_req.a = MUL_A_W'(p1_q);
				mul_req.b = MUL_B_W'(item_q.ds_mag);
			end
			OP_CFF: begin
				mul_req.a = MUL_A_W'(item_q.hz);
				mul_req.b = MUL_B_W'(rho_mag);
			end
			OP_MOM: begin
				mul_req.a = MUL_A_W'(inner_abs[62:0]);
				mul_req.b = MUL_B_W'(item_q.hz);
			end
			OP_D1: begin
				mul_req.a = MUL_A_W'(cfg.rho0);
				mul_req.b = item_q.d_mag;
			end
			OP_D2: begin
				mul_req.a = den1_q;
				mul_req.b = item_q.d_mag;
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	always_comb begin
		div_req.start = (state_q == ST_DISSUE);
		div_req.pert  = div_pert_q;
		div_req.num   = div_pert_q ? ms_abs[DIV_MAG_W-1:0] : ws_abs[DIV_MAG_W-1:0];
		div_req.den   = div_pert_q ? den2_q : DIV_DEN_W'(den1_q);
	end

	// round-half-away products, sign applied afterwards
	assign rnd46    = mul_rsp.prod + (MUL_P_W'(1) << 45);
	assign rnd16    = mul_rsp.prod + (MUL_P_W'(1) << 15);
	assign rnd17    = mul_rsp.prod + (MUL_P_W'(1) << 16);
	assign term_mag = TERM_W'(rnd46[MUL_P_W-1:46]);
	assign term_neg = ~term_mag + TERM_W'(1);
	assign cff_mag  = 64'(rnd16[62:16]);
	// a scaled bit at weight 2^63 or above saturates the increment
	assign inc_mag  = (|rnd17[MUL_P_W-1:80]) ? 64'(MAG_MAX) : 64'(rnd17[79:17]);
	assign quot_ext = 64'(div_rsp.quot);

	assign rho_sum = $signed(SUM_W'(cfg.r0)) - {tt_q[TERM_W-1], tt_q}
		+ {ts_q[TERM_W-1], ts_q} - ANOMALY_OFFSET;

	assign out_free = !out_valid_q || results.ready;
	assign pop      = (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_TC;
			item_q      <= '0;
			p1_q        <= '0;
			p1_neg_q    <= 1'b0;
			tt_q        <= '0;
			ts_q        <= '0;
			rho_q       <= '0;
			cff_q       <= '0;
			inner_q     <= '0;
			inc_q       <= '0;
			ws_q        <= '0;
			ms_q        <= '0;
			den1_q      <= '0;
			den2_q      <= '0;
			err_q       <= 1'b0;
			ratio_q     <= '0;
			pert_q      <= '0;
			div_pert_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_rho_q   <= '0;
			out_done_q  <= 1'b0;
			out_ratio_q <= '0;
			out_pert_q  <= '0;
			out_err_q   <= 1'b0;
		end else begin
			if (out_valid_q && results.ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						item_q  <= q_item;
						err_q   <= 1'b0;
						ratio_q <= '0;
						pert_q  <= '0;
						op_q    <= OP_TC;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (mul_rsp.done) begin
						unique case (op_q)
							OP_TC: begin
								p1_q     <= mul_rsp.prod[61:0];
								p1_neg_q <= cfg.tc_neg;
								op_q     <= OP_TD;
								state_q  <= ST_ISSUE;
							end
							OP_TD: begin
								tt_q    <= (p1_neg_q ^ item_q.dt_neg) ? term_neg : term_mag;
								op_q    <= OP_SC;
								state_q <= ST_ISSUE;
							end
							OP_SC: begin
								p1_q     <= mul_rsp.prod[61:0];
								p1_neg_q <= cfg.sc_neg;
								op_q     <= OP_SD;
								state_q  <= ST_ISSUE;
							end
							OP_SD: begin
								ts_q    <= (p1_neg_q ^ item_q.ds_neg) ? term_neg : term_mag;
								state_q <= ST_RHO;
							end
							OP_CFF: begin
								cff_q   <= rho_q[31] ? (~cff_mag + 64'd1) : cff_mag;
								state_q <= ST_INNER;
							end
							OP_MOM: begin
								inc_q   <= inner_q[63] ? (~inc_mag + 64'd1) : inc_mag;
								state_q <= ST_ACC;
							end
							OP_D1: begin
								den1_q <= mul_rsp.prod[63:0];
								if (mul_rsp.prod[63:0] == '0) begin
									err_q   <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									op_q    <= OP_D2;
									state_q <= ST_ISSUE;
								end
							end
							OP_D2: begin
								den2_q     <= mul_rsp.prod;
								div_pert_q <= 1'b0;
								state_q    <= ST_DISSUE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RHO: begin
					if (rho_sum > RHO_MAX) begin
						rho_q <= 32'sh7FFF_FFFF;
					end else if (rho_sum < RHO_MIN) begin
						rho_q <= 32'sh8000_0000;
					end else begin
						rho_q <= rho_sum[31:0];
					end
					op_q    <= OP_CFF;
					state_q <= ST_ISSUE;
				end
				ST_INNER: begin
					inner_q <= sat_add(sat_add(ws_q, ws_q), cff_q);
					ws_q    <= sat_add(ws_q, cff_q);
					op_q    <= OP_MOM;
					state_q <= ST_ISSUE;
				end
				ST_ACC: begin
					ms_q <= sat_add(ms_q, inc_q);
					if (item_q.last) begin
						op_q    <= OP_D1;
						state_q <= ST_ISSUE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DISSUE: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_rsp.done) begin
						if (!div_pert_q) begin
							ratio_q <= (ws_q[63] ^ item_q.d_neg) ? (~quot_ext + 64'd1)
								: quot_ext;
							div_pert_q <= 1'b1;
							state_q    <= ST_DISSUE;
						end else begin
							pert_q  <= ms_q[63] ? (~quot_ext + 64'd1) : quot_ext;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					// hold until the output register frees up
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_rho_q   <= rho_q;
						out_done_q  <= item_q.last;
						out_ratio_q <= ratio_q;
						out_pert_q  <= pert_q;
						out_err_q   <= err_q;
						if (item_q.last) begin
							ws_q <= '0;
							ms_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid                = out_valid_q;
	assign results.density_anomaly      = out_rho_q;
	assign results.column_done          = out_done_q;
	assign results.mean_density_ratio   = out_ratio_q;
	assign results.density_perturbation = out_pert_q;
	assign results.depth_error          = out_err_q;

endmodule

`default_nettype wire

// ===== rtl/core/linear_eos_column_density_top.sv =====
// An inner level goes from queue pop to the output register through six
// products on the shared 64x33 multiplier. The last level of a column adds
// two extra products and two radix-2 divisions of 128 and 145 steps, one quotient bit per cycle.
// The sequencer pops a new level only after the previous result has entered
// the output register; a two-entry queue takes levels in while the result waits.
// Reset: asynchronous; clears sums, loads defaults.
// ----------------------------------------------------------------------------
// linear_eos_column_density_top: linear equation of state over a water column
// Per-level density anomaly, running column sums and, on the bottom level,
// the vertically averaged density ratio and perturbation, or a depth error.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_eos_column_density_top (
	input  logic                             clk,
	input  logic                             arst_n,
	lecd_in_if.sink                          levels,
	lecd_out_if.source                       results,
	input  logic                             cfg_wr_en,
	input  logic [lecd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lecd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lecd_pkg::*;

	cfg_t  cfg;
	item_t front_item;
	item_t q_item;
	logic  q_push;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;

	lecd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.levels    (levels),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.item      (front_item),
		.push      (q_push),
		.full      (q_full)
	);

	lecd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_item (front_item),
		.push    (q_push),
		.full    (q_full),
		.rd_item (q_item),
		.empty   (q_empty),
		.pop     (q_pop)
	);

	lecd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_item  (q_item),
		.q_empty (q_empty),
		.pop     (q_pop),
		.results (results)
	);

`ifndef SYNTHESIS
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		levels.valid && levels.ready |=> !q_empty)
		else $error("accepted level missing from queue");

	a_inner_no_avg: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.column_done |->
			results.mean_density_ratio == 64'sd0 &&
			results.density_perturbation == 64'sd0 && !results.depth_error)
		else $error("column averages on an inner level");

	a_err_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.depth_error |->
			results.column_done && results.mean_density_ratio == 64'sd0 &&
			results.density_perturbation == 64'sd0)
		else $error("depth error with nonzero averages");
`endif

endmodule

`default_nettype wire

// ===== verif/linear_eos_column_density_top_test.sv =====
// ----------------------------------------------------------------------------
// linear_eos_column_density_top_test: self-checking bench for the column block
// Feeds water columns level by level through the valid/ready channel, predicts
// every result with a wide-integer copy of the arithmetic, and checks each
// result transaction in order under random bursts, stalls and config phases.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_eos_column_density_top_test;
	import lecd_pkg::*;

	localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint ANOMALY_OFFSET = 64'sd65536000;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int LONG_HOLD = 500;

	typedef struct {
		logic signed [31:0] temp;
		logic signed [31:0] salt;
		logic [30:0]        hz;
		logic signed [31:0] zs;
		logic signed [31:0] hb;
		logic               last;
	} level_t;

	typedef struct {
		logic signed [31:0] anomaly;
		logic               done;
		logic [63:0]        ratio;
		logic [63:0]        pert;
		logic               err;
	} column_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lecd_in_if levels_if ();
	lecd_out_if results_if ();

	linear_eos_column_density_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.levels    (levels_if.sink),
		.results   (results_if.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of the registers and the running sums
	logic [30:0]        eos_r0;
	logic signed [31:0] eos_t0;
	logic signed [31:0] eos_s0;
	logic signed [31:0] eos_tc;
	logic signed [31:0] eos_sc;
	logic [30:0]        eos_rho0;
	longint             weighted_acc;
	longint             moment_acc;

	level_t         pending_levels[$];
	column_result_t expected_results[$];
	int             errors;
	int             results_seen;
	int             cycles;
	logic           level_taken;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint sat_add(longint a, longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > SAT_MAX)
			return SAT_MAX;
		if (s < -SAT_MAX)
			return -SAT_MAX;
		return s[63:0];
	endfunction

	// round(a*b / 2^sh), ties away from zero, saturated
	function automatic longint round_mul(longint a, longint b, int sh);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [127:0] p;
		longint       m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = {64'b0, ma} * {64'b0, mb};
		p = (p + (128'd1 << (sh - 1))) >> sh;
		m = (p > 128'(SAT_MAX)) ? SAT_MAX : p[63:0];
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint round_div(logic [63:0] num, int sh, logic [127:0] den);
		logic [255:0] q;
		q = ((256'(num) << (sh + 1)) + 256'(den)) / (256'(den) << 1);
		return (q > 256'(SAT_MAX)) ? SAT_MAX : q[63:0];
	endfunction

	function automatic column_result_t column_step(level_t lv);
		column_result_t r;
		longint rho, cff, inner, d, qa, qs;
		logic [63:0]  dm;
		logic [63:0]  den1;
		logic [127:0] den2;
		rho = longint'(eos_r0)
			- round_mul(longint'(eos_r0) * longint'(eos_tc), longint'(lv.temp) - longint'(eos_t0), 46)
			+ round_mul(longint'(eos_r0) * longint'(eos_sc), longint'(lv.salt) - longint'(eos_s0), 46)
			- ANOMALY_OFFSET;
		if (rho > 64'sd2147483647)
			rho = 64'sd2147483647;
		if (rho < -64'sd2147483648)
			rho = -64'sd2147483648;
		cff = round_mul(rho, longint'(lv.hz), 16);
		inner = sat_add(sat_add(weighted_acc, weighted_acc), cff);
		moment_acc = sat_add(moment_acc, round_mul(inner, longint'(lv.hz), 17));
		weighted_acc = sat_add(weighted_acc, cff);
		r.anomaly = rho[31:0];
		r.done = lv.last;
		r.ratio = '0;
		r.pert = '0;
		r.err = 1'b0;
		if (lv.last) begin
			d = longint'(lv.zs) + longint'(lv.hb);
			dm = (d < 0) ? -d : d;
			den1 = 64'(eos_rho0) * dm;
			if (den1 == 0) begin
				r.err = 1'b1;
			end else begin
				den2 = 128'(den1) * 128'(dm);
				qa = round_div((weighted_acc < 0) ? -weighted_acc : weighted_acc, 64, 128'(den1));
				qs = round_div((moment_acc < 0) ? -moment_acc : moment_acc, 81, den2);
				r.ratio = ((weighted_acc < 0) != (d < 0)) ? -qa : qa;
				r.pert = (moment_acc < 0) ? -qs : qs;
			end
			weighted_acc = 0;
			moment_acc = 0;
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// accept levels and check results at the rising edge
	always @(posedge clk) begin
		column_result_t exp_r;
		level_taken <= arst_n && levels_if.valid && levels_if.ready;
		if (arst_n) begin
			if (levels_if.valid && levels_if.ready) begin
				expected_results.push_back(column_step(pending_levels.pop_front()));
			end
			if (results_if.valid && results_if.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t unexpected result transaction: anomaly %h",
						$time, results_if.density_anomaly);
				end else begin
					exp_r = expected_results.pop_front();
					check_field("density_anomaly", 64'(exp_r.anomaly),
						64'(results_if.density_anomaly));
					check_field("column_done", 64'(exp_r.done), 64'(results_if.column_done));
					check_field("mean_density_ratio", exp_r.ratio, results_if.mean_density_ratio);
					check_field("density_perturbation", exp_r.pert,
						results_if.density_perturbation);
					check_field("depth_error", 64'(exp_r.err), 64'(results_if.depth_error));
				end
			end
		end
	end

	// sender: bursts of random length, random gaps, some gapless stretches
	int burst_left;
	int gap_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			levels_if.valid <= 1'b0;
		end else if (!levels_if.valid || level_taken) begin
			// a taken head is already gone from the pending queue
			if (gap_left > 0) begin
				gap_left--;
				levels_if.valid <= 1'b0;
			end else if (pending_levels.size() > 0) begin
				levels_if.valid <= 1'b1;
				levels_if.temperature <= pending_levels[0].temp;
				levels_if.salinity <= pending_levels[0].salt;
				levels_if.layer_thickness <= pending_levels[0].hz;
				levels_if.surface_height <= pending_levels[0].zs;
				levels_if.bottom_depth <= pending_levels[0].hb;
				levels_if.last_level <= pending_levels[0].last;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				levels_if.valid <= 1'b0;
			end
		end
	end

	// receiver: own stall pattern, plus long holds to back the block up
	int hold_left;
	int next_hold_at;
	int stall_mode;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			results_if.ready <= 1'b0;
		end else if (arst_n && results_seen >= next_hold_at) begin
			hold_left = LONG_HOLD;
			next_hold_at = next_hold_at + 400;
			results_if.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: results_if.ready <= 1'b1;
				1: results_if.ready <= ($urandom_range(0, 3) != 0);
				default: results_if.ready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			CFG_REF_DENSITY:     eos_r0 = v[30:0];
			CFG_REF_TEMPERATURE: eos_t0 = v;
			CFG_REF_SALINITY:    eos_s0 = v;
			CFG_THERMAL_COEF:    eos_tc = v;
			CFG_HALINE_COEF:     eos_sc = v;
			CFG_MEAN_DENSITY:    eos_rho0 = v[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		wait (pending_levels.size() == 0 && expected_results.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic level_t make_level(bit noisy, bit last);
		level_t lv;
		if (noisy) begin
			lv.temp = $urandom;
			lv.salt = $urandom;
			lv.hz = $urandom;
			lv.zs = $urandom;
			lv.hb = $urandom;
		end else begin
			lv.temp = $signed($urandom_range(0, 32 << 16)) - (2 << 16);
			lv.salt = $urandom_range(30 << 16, 40 << 16);
			lv.hz = $urandom_range(1 << 14, 200 << 16);
			lv.zs = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
			lv.hb = $urandom_range(5 << 16, 4000 << 16);
		end
		// now and then a zero or negative total depth
		if (last && $urandom_range(0, 15) == 0)
			lv.hb = -lv.zs;
		else if (last && $urandom_range(0, 15) == 0)
			lv.hb = -lv.hb;
		lv.last = last;
		return lv;
	endfunction

	task automatic queue_columns(int n_levels);
		int n;
		int len;
		bit noisy;
		n = 0;
		while (n < n_levels) begin
			len = ($urandom_range(0, 40) == 0) ? $urandom_range(65, 80) : $urandom_range(1, 10);
			noisy = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++)
				pending_levels.push_back(make_level(noisy && $urandom_range(0, 1), i == len - 1));
			n += len;
		end
	endtask

	task automatic queue_level(logic signed [31:0] t, logic signed [31:0] s, logic [30:0] hz,
		logic signed [31:0] zs, logic signed [31:0] hb, logic last);
		level_t lv;
		lv.temp = t;
		lv.salt = s;
		lv.hz = hz;
		lv.zs = zs;
		lv.hb = hb;
		lv.last = last;
		pending_levels.push_back(lv);
	endtask

	initial begin
		cycles = 0;
		errors = 0;
		results_seen = 0;
		burst_left = 0;
		gap_left = 0;
		hold_left = 0;
		next_hold_at = 150;
		stall_mode = 1;
		weighted_acc = 0;
		moment_acc = 0;
		eos_r0 = RST_REF_DENSITY;
		eos_t0 = RST_REF_TEMPERATURE;
		eos_s0 = RST_REF_SALINITY;
		eos_tc = RST_THERMAL_COEF;
		eos_sc = RST_HALINE_COEF;
		eos_rho0 = RST_MEAN_DENSITY;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_REF_DENSITY;
		cfg_data = '0;
		levels_if.valid = 1'b0;
		levels_if.temperature = '0;
		levels_if.salinity = '0;
		levels_if.layer_thickness = '0;
		levels_if.surface_height = '0;
		levels_if.bottom_depth = '0;
		levels_if.last_level = 1'b0;
		results_if.ready = 1'b1;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// field extremes, single-level column, zero and negative depth
		queue_level(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 1'b0);
		queue_level(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 1'b0);
		queue_level(10 << 16, 35 << 16, 31'd0, 0, 0, 1'b0);
		queue_level(15 << 16, 34 << 16, 31'd65536, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
		queue_level(5 << 16, 36 << 16, 31'd655360, 0, 100 << 16, 1'b1);
		queue_level(5 << 16, 36 << 16, 31'd655360, 3 << 16, -(3 << 16), 1'b1);
		queue_level(20 << 16, 33 << 16, 31'd1 << 20, 1 << 16, 200 << 16, 1'b0);
		queue_level(2 << 16, 35 << 16, 31'd1 << 21, 1 << 16, 200 << 16, 1'b1);
		queue_level(0, 0, 31'd100 << 16, 0, -(50 << 16), 1'b1);
		queue_level(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 1'b1);
		queue_level(-1, -1, 31'd1, 0, 1, 1'b1);
		queue_level(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 0, 1'b1);
		wait_idle();
		queue_columns(220);
		wait_idle();

		// extremes of the registers, one way
		write_reg(CFG_REF_DENSITY, 32'h7FFF_FFFF);
		write_reg(CFG_REF_TEMPERATURE, 32'h8000_0000);
		write_reg(CFG_REF_SALINITY, 32'h7FFF_FFFF);
		write_reg(CFG_THERMAL_COEF, 32'h7FFF_FFFF);
		write_reg(CFG_HALINE_COEF, 32'h8000_0000);
		write_reg(CFG_MEAN_DENSITY, 32'h0001_0000);
		write_reg(CFG_UNUSED_LO, $urandom);
		queue_columns(150);
		wait_idle();

		// and the other way
		write_reg(CFG_REF_DENSITY, 32'h0);
		write_reg(CFG_REF_TEMPERATURE, 32'h7FFF_FFFF);
		write_reg(CFG_REF_SALINITY, 32'h8000_0000);
		write_reg(CFG_THERMAL_COEF, 32'h8000_0000);
		write_reg(CFG_HALINE_COEF, 32'h7FFF_FFFF);
		write_reg(CFG_MEAN_DENSITY, 32'hFFFF_FFFF);
		write_reg(CFG_UNUSED_HI, $urandom);
		queue_columns(150);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			if (ph[0]) begin
				write_reg(CFG_REF_DENSITY, $urandom);
				write_reg(CFG_REF_TEMPERATURE, $urandom);
				write_reg(CFG_REF_SALINITY, $urandom);
				write_reg(CFG_THERMAL_COEF, $urandom);
				write_reg(CFG_HALINE_COEF, $urandom);
				write_reg(CFG_MEAN_DENSITY, $urandom_range(32'h0001_0000, 32'h7FFF_FFFF));
			end else begin
				write_reg(CFG_REF_DENSITY, $urandom_range(1000 << 16, 1050 << 16));
				write_reg(CFG_REF_TEMPERATURE, $urandom_range(0, 25 << 16));
				write_reg(CFG_REF_SALINITY, $urandom_range(30 << 16, 38 << 16));
				write_reg(CFG_THERMAL_COEF, $urandom_range(0, 1 << 20));
				write_reg(CFG_HALINE_COEF, $urandom_range(0, 1 << 21));
				write_reg(CFG_MEAN_DENSITY, $urandom_range(1000 << 16, 1050 << 16));
			end
			queue_columns(200);
			wait_idle();
		end

		wait (pending_levels.size() == 0 && expected_results.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/lecd_pkg.sv
rtl/core/lecd_if.sv
rtl/core/lecd_front.sv
rtl/core/lecd_queue.sv
rtl/core/lecd_mul.sv
rtl/core/lecd_div.sv
rtl/core/lecd_back.sv
rtl/core/linear_eos_column_density_top.sv
verif/linear_eos_column_density_top_test.sv
